// File: rtl/swt_pkg.sv
// Shared types and constants of the shell word tokenizer.
package swt_pkg;

  localparam int CHAR_W = 8;
  localparam int KIND_W = 3;
  localparam int CFG_W  = 13;
  localparam logic [CFG_W-1:0] CAP_RESET = 13'd256;

  // result queue: two slots per item plus room to keep streaming
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int QCW    = 3;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_BSL   = 8'h5c;
  localparam logic [CHAR_W-1:0] CH_SQ    = 8'h27;
  localparam logic [CHAR_W-1:0] CH_DQ    = 8'h22;

  typedef enum logic [1:0] {
    PH_SKIP  = 2'd0,
    PH_WORD  = 2'd1,
    PH_ERROR = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    Q_NONE   = 2'd0,
    Q_SINGLE = 2'd1,
    Q_DOUBLE = 2'd2
  } quote_t;

  typedef enum logic [KIND_W-1:0] {
    K_CHAR     = 3'd0,
    K_END      = 3'd1,
    K_NOMORE   = 3'd2,
    K_UNCLOSED = 3'd3,
    K_TOOLONG  = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [CHAR_W-1:0] ch;
    logic              last;
  } result_t;

endpackage

// File: rtl/swt_if.sv
// Channel interfaces of the shell word tokenizer.
interface swt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  modport source (output valid, output char_byte, input ready);
  modport sink (input valid, input char_byte, output ready);
endinterface

interface swt_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] result_kind;
  logic [7:0] char_value;
  logic       last_of_command;
  modport source (output valid, output result_kind, output char_value,
                  output last_of_command, input ready);
  modport sink (input valid, input result_kind, input char_value,
                input last_of_command, output ready);
endinterface

interface swt_cfg_if;
  logic        valid;
  logic        ready;
  logic [12:0] token_capacity;
  modport source (output valid, output token_capacity, input ready);
  modport sink (input valid, input token_capacity, output ready);
endinterface

// File: rtl/shell_word_tokenizer.sv
// Shell-style word splitter with quotes and backslash escapes.
//
//   channel   dir  handshake          payload
//   in_chan   in   valid/ready        char_byte
//   out_chan  out  valid/ready        result_kind, char_value, last_of_command
//   cfg_chan  in   valid/ready (=1)   token_capacity
//
// One byte per cycle unless stalled: a byte is held and decoded in the input
// register; its zero, one or two results drop into a four-entry result queue.
// Results leave one per cycle while out_chan.ready is high; only a backslash
// right before a zero gives two; input stalls unless the queue has room for two.
// Reset (rst_n low, synchronous) empties both stages and sets capacity 256.
module shell_word_tokenizer #(
  parameter int MAX_CAPACITY = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  swt_in_if.sink     in_chan,
  swt_out_if.source  out_chan,
  swt_cfg_if.sink    cfg_chan
);
  import swt_pkg::*;

  localparam int CAPW = $clog2(MAX_CAPACITY + 1);
  localparam int LENW = $clog2(MAX_CAPACITY);
  localparam int CMPW = ((CAPW > CFG_W) ? CAPW : CFG_W) + 1;

  logic [CFG_W-1:0]  cap_r;
  logic              in_v_r;
  logic [CHAR_W-1:0] byte_r;
  phase_t            phase_r, phase_nxt;
  quote_t            quote_r, quote_nxt;
  logic              esc_r, esc_nxt;
  logic [LENW-1:0]   len_r, len_nxt;

  result_t           q_r [QDEPTH];
  logic [QAW-1:0]    head_r, tail_r;
  logic [QCW-1:0]    cnt_r;

  logic              adv, pop;
  logic [QCW-1:0]    cnt_after_pop;
  logic [1:0]        n_res;
  result_t           res0, res1;

  quote_t            eq;
  logic              eesc;
  logic [LENW-1:0]   elen;
  logic [CMPW-1:0]   cap_eff, len_inc;
  logic              fits, is_ws, in_word;
  quote_t            qsel;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_chan.valid) begin
      cap_r <= cfg_chan.token_capacity;
    end
  end

  // input register
  assign pop           = out_chan.valid && out_chan.ready;
  assign cnt_after_pop = cnt_r - QCW'(pop);
  assign adv           = in_v_r && (cnt_after_pop <= QCW'(QDEPTH - 2));
  assign in_chan.ready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      byte_r <= in_chan.char_byte;
    end
  end

  // decode
  assign cap_eff = (CMPW'(cap_r) > CMPW'(MAX_CAPACITY)) ? CMPW'(MAX_CAPACITY)
                                                         : CMPW'(cap_r);
  assign in_word = (phase_r == PH_WORD);
  // a new word starts with clear word state
  assign eq      = in_word ? quote_r : Q_NONE;
  assign eesc    = in_word ? esc_r : 1'b0;
  assign elen    = in_word ? len_r : '0;
  assign len_inc = CMPW'(elen) + CMPW'(1);
  assign fits    = len_inc < cap_eff;
  assign is_ws   = (byte_r == CH_SPACE) || (byte_r == CH_TAB);
  assign qsel    = (byte_r == CH_SQ) ? Q_SINGLE : Q_DOUBLE;

  always_comb begin
    phase_nxt = phase_r;
    quote_nxt = quote_r;
    esc_nxt   = esc_r;
    len_nxt   = len_r;
    n_res     = 2'd0;
    res0      = '{kind: K_CHAR, ch: byte_r, last: 1'b0};
    res1      = '{kind: K_END, ch: CH_NUL, last: 1'b1};
    if (phase_r == PH_ERROR) begin
      if (byte_r == CH_NUL) begin
        phase_nxt = PH_SKIP;
        quote_nxt = Q_NONE;
        esc_nxt   = 1'b0;
        len_nxt   = '0;
      end
    end else if (!in_word && is_ws) begin
      // whitespace between words: nothing
    end else if (!in_word && byte_r == CH_NUL) begin
      n_res     = 2'd1;
      res0      = '{kind: K_NOMORE, ch: CH_NUL, last: 1'b1};
      phase_nxt = PH_SKIP;
    end else begin
      phase_nxt = PH_WORD;
      quote_nxt = eq;
      esc_nxt   = eesc;
      len_nxt   = elen;
      priority if (byte_r == CH_NUL) begin
        phase_nxt = PH_SKIP;
        quote_nxt = Q_NONE;
        esc_nxt   = 1'b0;
        len_nxt   = '0;
        res1.kind = (eq != Q_NONE) ? K_UNCLOSED : K_END;
        if (!eesc) begin
          n_res = 2'd1;
          res0  = res1;
        end else if (!fits) begin
          n_res = 2'd1;
          res0  = '{kind: K_TOOLONG, ch: CH_NUL, last: 1'b1};
        end else begin
          // trailing backslash is kept, then the word closes
          n_res = 2'd2;
          res0  = '{kind: K_CHAR, ch: CH_BSL, last: 1'b0};
        end
      end else if (eesc) begin
        esc_nxt = 1'b0;
        n_res   = 2'd1;
        if (fits) begin
          len_nxt = elen + LENW'(1);
        end else begin
          res0      = '{kind: K_TOOLONG, ch: CH_NUL, last: 1'b1};
          phase_nxt = PH_ERROR;
        end
      end else if (eq == Q_NONE && is_ws) begin
        n_res     = 2'd1;
        res0      = '{kind: K_END, ch: CH_NUL, last: 1'b0};
        phase_nxt = PH_SKIP;
        quote_nxt = Q_NONE;
        len_nxt   = '0;
      end else if (byte_r == CH_BSL) begin
        esc_nxt = 1'b1;
      end else if ((byte_r == CH_SQ || byte_r == CH_DQ) && eq == Q_NONE) begin
        quote_nxt = qsel;
      end else if ((byte_r == CH_SQ || byte_r == CH_DQ) && eq == qsel) begin
        quote_nxt = Q_NONE;
      end else begin
        n_res = 2'd1;
        if (fits) begin
          len_nxt = elen + LENW'(1);
        end else begin
          res0      = '{kind: K_TOOLONG, ch: CH_NUL, last: 1'b1};
          phase_nxt = PH_ERROR;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SKIP;
      quote_r <= Q_NONE;
      esc_r   <= 1'b0;
      len_r   <= '0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      quote_r <= quote_nxt;
      esc_r   <= esc_nxt;
      len_r   <= len_nxt;
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_r + QAW'(pop);
      tail_r <= tail_r + (adv ? QAW'(n_res) : QAW'(0));
      cnt_r  <= cnt_after_pop + (adv ? QCW'(n_res) : QCW'(0));
    end
  end

  always_ff @(posedge clk) begin
    if (adv && n_res != 2'd0) begin
      q_r[tail_r] <= res0;
    end
    if (adv && n_res == 2'd2) begin
      q_r[tail_r + QAW'(1)] <= res1;
    end
  end

  assign out_chan.valid           = (cnt_r != '0);
  assign out_chan.result_kind     = q_r[head_r].kind;
  assign out_chan.char_value      = q_r[head_r].ch;
  assign out_chan.last_of_command = q_r[head_r].last;

endmodule

// File: test/testbench.sv
// Self-checking testbench for the shell word tokenizer: byte stream in, word results out.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import swt_pkg::*;

  localparam int MAX_CAP = 4096;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n;

  swt_in_if  in_if();
  swt_out_if out_if();
  swt_cfg_if cfg_if();

  shell_word_tokenizer #(.MAX_CAPACITY(MAX_CAP)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // tokenizer state as seen by the predictor
  phase_t      scan_phase = PH_SKIP;
  quote_t      open_q     = Q_NONE;
  bit          esc_armed  = 1'b0;
  int          word_len   = 0;
  logic [12:0] cur_cap    = CAP_RESET;

  result_t awaited_tokens[$];
  int      mismatches = 0;
  int      bytes_sent = 0;
  int      cycle_count = 0;
  bit      calm = 1'b0;

  function automatic void queue_token(input kind_t k, input logic [7:0] c, input logic l);
    result_t r;
    r.kind = k;
    r.ch   = c;
    r.last = l;
    awaited_tokens.push_back(r);
  endfunction

  function automatic void clear_word();
    open_q    = Q_NONE;
    esc_armed = 1'b0;
    word_len  = 0;
  endfunction

  // returns 0 when the word would reach the buffer size
  function automatic bit keep_char(input logic [7:0] c);
    int lim;
    lim = (int'(cur_cap) > MAX_CAP) ? MAX_CAP : int'(cur_cap);
    if (word_len + 1 >= lim) begin
      queue_token(K_TOOLONG, CH_NUL, 1'b1);
      return 1'b0;
    end
    queue_token(K_CHAR, c, 1'b0);
    word_len++;
    return 1'b1;
  endfunction

  function automatic void split_byte(input logic [7:0] b);
    bit     ok;
    quote_t qk;
    if (scan_phase == PH_ERROR) begin
      if (b == CH_NUL) begin
        scan_phase = PH_SKIP;
        clear_word();
      end
      return;
    end
    if (scan_phase != PH_WORD) begin
      if (b == CH_SPACE || b == CH_TAB) return;
      if (b == CH_NUL) begin
        scan_phase = PH_SKIP;
        queue_token(K_NOMORE, CH_NUL, 1'b1);
        return;
      end
      scan_phase = PH_WORD;
      clear_word();
    end
    if (b == CH_NUL) begin
      ok = 1'b1;
      // a trailing backslash is kept literally
      if (esc_armed) ok = keep_char(CH_BSL);
      if (ok) begin
        if (open_q != Q_NONE) queue_token(K_UNCLOSED, CH_NUL, 1'b1);
        else queue_token(K_END, CH_NUL, 1'b1);
      end
      scan_phase = PH_SKIP;
      clear_word();
      return;
    end
    if (esc_armed) begin
      esc_armed = 1'b0;
      if (!keep_char(b)) scan_phase = PH_ERROR;
      return;
    end
    if (open_q == Q_NONE && (b == CH_SPACE || b == CH_TAB)) begin
      scan_phase = PH_SKIP;
      clear_word();
      queue_token(K_END, CH_NUL, 1'b0);
      return;
    end
    if (b == CH_BSL) begin
      esc_armed = 1'b1;
      return;
    end
    if (b == CH_SQ || b == CH_DQ) begin
      qk = (b == CH_SQ) ? Q_SINGLE : Q_DOUBLE;
      if (open_q == Q_NONE) begin
        open_q = qk;
        return;
      end
      if (open_q == qk) begin
        open_q = Q_NONE;
        return;
      end
    end
    if (!keep_char(b)) scan_phase = PH_ERROR;
  endfunction

  task automatic push_byte(input logic [7:0] b);
    while (!calm && $urandom_range(99) < 7) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.char_byte <= b;
    do @(posedge clk); while (!in_if.ready);
    split_byte(b);
    bytes_sent++;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (awaited_tokens.size() != 0) @(posedge clk);
    // a last byte may still be in flight without any result
    repeat (6) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [12:0] v);
    drain();
    cfg_if.valid          <= 1'b1;
    cfg_if.token_capacity <= v;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    cur_cap = v;
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255, 1));
    while (b == CH_SPACE || b == CH_TAB || b == CH_SQ || b == CH_DQ || b == CH_BSL);
    return b;
  endfunction

  function automatic logic [7:0] quoted_byte(input logic [7:0] q);
    logic [7:0] b;
    do b = 8'($urandom_range(255, 1));
    while (b == q || b == CH_BSL);
    return b;
  endfunction

  // mostly well-formed words with random content, some noise and broken quoting
  task automatic send_command(input int max_words);
    int         nw;
    int         ns;
    logic [7:0] q;
    nw = $urandom_range(max_words);
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(12)) push_byte(8'($urandom_range(255, 1)));
    end else begin
      for (int w = 0; w < nw; w++) begin
        repeat ($urandom_range(2)) push_byte($urandom_range(1) ? CH_SPACE : CH_TAB);
        ns = $urandom_range(4, 1);
        for (int s = 0; s < ns; s++) begin
          case ($urandom_range(3))
            0: push_byte(plain_byte());
            1: begin
              push_byte(CH_BSL);
              push_byte(8'($urandom_range(255, 1)));
            end
            default: begin
              q = $urandom_range(1) ? CH_SQ : CH_DQ;
              push_byte(q);
              repeat ($urandom_range(4)) begin
                if ($urandom_range(5) == 0) begin
                  push_byte(CH_BSL);
                  push_byte(8'($urandom_range(255, 1)));
                end else begin
                  push_byte(quoted_byte(q));
                end
              end
              if ($urandom_range(15) != 0) push_byte(q);
            end
          endcase
        end
      end
      if ($urandom_range(1)) push_byte($urandom_range(1) ? CH_SPACE : CH_TAB);
    end
    if ($urandom_range(11) == 0) push_byte(CH_BSL);
    push_byte(CH_NUL);
  endtask

  task automatic test_directed_cases();
    logic [7:0] seq[$] = '{CH_NUL, CH_TAB, CH_SQ, "a", CH_DQ, CH_SQ, CH_DQ, CH_DQ,
                           CH_SPACE, CH_BSL, CH_NUL, 8'hff, 8'h01, CH_DQ, "x", CH_NUL,
                           CH_SQ, CH_SQ, CH_NUL, CH_BSL, CH_SQ, CH_BSL, CH_SPACE, "b",
                           CH_NUL};
    foreach (seq[i]) push_byte(seq[i]);
  endtask

  task automatic test_capacity_edges();
    set_capacity(13'd0);
    push_byte("a");
    push_byte("b");
    push_byte(CH_NUL);
    push_byte(CH_NUL);
    // error raised on the terminating zero
    set_capacity(13'd1);
    push_byte(CH_BSL);
    push_byte(CH_NUL);
    push_byte(CH_NUL);
    set_capacity(13'd2);
    push_byte("x");
    push_byte("y");
    push_byte(CH_SPACE);
    push_byte("q");
    push_byte(CH_NUL);
    push_byte(CH_NUL);
    set_capacity(13'd3);
    push_byte("a");
    push_byte(CH_BSL);
    push_byte(CH_NUL);
    // above the maximum: acts as the maximum, so short words pass whole
    set_capacity(13'd4097);
    push_byte("a");
    push_byte("b");
    push_byte(CH_NUL);
    set_capacity(13'h1fff);
    push_byte("z");
    push_byte(CH_BSL);
    push_byte(CH_SPACE);
    push_byte(CH_NUL);
  endtask

  task automatic test_random_commands();
    logic [12:0] cap;
    int          target;
    for (int r = 0; r < 12; r++) begin
      case (r % 4)
        0: cap = 13'($urandom_range(24, 2));
        1: cap = 13'd4096;
        2: cap = 13'($urandom_range(8191, 1));
        default: cap = 13'($urandom_range(6, 1));
      endcase
      calm = (r == 5);
      set_capacity(cap);
      target = bytes_sent + 130;
      while (bytes_sent < target) send_command(4);
    end
    calm = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= calm || ($urandom_range(99) >= 7);
    end
  end

  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (awaited_tokens.size() == 0) begin
        $display("%0t: unexpected result, expected none, got kind %0d char %02h last %0d",
                 $time, out_if.result_kind, out_if.char_value, out_if.last_of_command);
        mismatches++;
      end else begin
        exp_r = awaited_tokens.pop_front();
        if (out_if.result_kind !== exp_r.kind || out_if.char_value !== exp_r.ch ||
            out_if.last_of_command !== exp_r.last) begin
          $display("%0t: expected kind %0d char %02h last %0d, got kind %0d char %02h last %0d",
                   $time, exp_r.kind, exp_r.ch, exp_r.last, out_if.result_kind,
                   out_if.char_value, out_if.last_of_command);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst_n                 = 1'b0;
    in_if.valid           = 1'b0;
    in_if.char_byte       = 8'h00;
    cfg_if.valid          = 1'b0;
    cfg_if.token_capacity = 13'd0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_capacity_edges();
    test_random_commands();

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
